/* rtl/rgb_to_ycbcr_420_top_defines.svh */
// ----------------------------------------------------------------------------
// RGB to YCbCr 4:2:0 converter - assertion macros
// Shared property shapes for the converter's internal checks.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YCBCR_420_TOP_DEFINES_SVH
`define RGB_TO_YCBCR_420_TOP_DEFINES_SVH

// ante holds at an edge -> cons holds at the same edge
`define RY420_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cond holds at every edge outside reset
`define RY420_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

/* rtl/ry420_pkg.sv */
// ----------------------------------------------------------------------------
// ry420_pkg - shared types and constants
// Widths, BT.601 Q0.16 coefficients, CSR indexes and word structs.
// ----------------------------------------------------------------------------
package ry420_pkg;

   localparam int PIX_W      = 8;
   localparam int SIZE_W     = 12;
   localparam int CNT_W      = 11;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = PIX_W + COEF_W;
   localparam int Q_W        = 24;
   localparam int SQ_W       = Q_W + 2;
   localparam int SUM_W      = 25;
   localparam int BLK_W      = SUM_W + 2;
   localparam int AVG_W      = BLK_W - FRAC_BITS;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int IDX_W      = $clog2(LINE_DEPTH);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;

   localparam int MID_DEPTH  = 4;
   localparam int MID_AW     = $clog2(MID_DEPTH);
   localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
   localparam int OUT_DEPTH  = 8;
   localparam int OUT_AW     = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

   typedef logic [PIX_W-1:0]      pix_type;
   typedef logic [SIZE_W-1:0]     size_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [COEF_W-1:0]     coef_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [Q_W-1:0]        q_type;
   typedef logic signed [SQ_W-1:0] sq_type;
   typedef logic [SUM_W-1:0]      sum_type;
   typedef logic [BLK_W-1:0]      blk_type;
   typedef logic [AVG_W-1:0]      avg_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [MID_AW-1:0]     mid_ptr_type;
   typedef logic [MID_CNT_W-1:0]  mid_cnt_type;
   typedef logic [OUT_AW-1:0]     out_ptr_type;
   typedef logic [OUT_CNT_W-1:0]  out_cnt_type;

   // CSR map
   localparam csr_idx_type CSR_SUBSAMPLE = csr_idx_type'(0);
   localparam csr_idx_type CSR_WIDTH     = csr_idx_type'(1);
   localparam csr_idx_type CSR_HEIGHT    = csr_idx_type'(2);

   localparam size_type RESET_WIDTH  = size_type'(640);
   localparam size_type RESET_HEIGHT = size_type'(480);

   // Q0.16 coefficients; the luma ones rounded to nearest
   localparam coef_type C_Y_R  = coef_type'(19595);
   localparam coef_type C_Y_G  = coef_type'(38470);
   localparam coef_type C_Y_B  = coef_type'(7471);
   localparam coef_type C_CB_R = coef_type'(11061);
   localparam coef_type C_CB_G = coef_type'(21712);
   localparam coef_type C_HALF = coef_type'(32768);
   localparam coef_type C_CR_G = coef_type'(27440);
   localparam coef_type C_CR_B = coef_type'(5329);

   localparam q_type Q_OFFSET = q_type'(128 << FRAC_BITS);
   localparam q_type Q_MAX    = q_type'(255 << FRAC_BITS);
   localparam q_type ROUND_Q  = q_type'(1 << (FRAC_BITS - 1));

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } pixel_type;

   typedef struct packed {
      pix_type luma;
      pix_type chroma_blue;
      pix_type chroma_red;
      logic    chroma_valid;
      logic    frame_end;
   } result_type;

   // chroma handling chosen by the front end
   typedef enum logic [1:0] {
      OP_PIXEL,   // 4:4:4, chroma per pixel
      OP_HOLD,    // first pixel of a pair, accumulate only
      OP_STORE,   // upper row pair done, park it in the line store
      OP_EMIT     // block done, average and output
   } op_type;

   typedef struct packed {
      pixel_type pixel;
      op_type    op;
      logic      pair_add;   // odd column: add to running pair sum
      logic      line_add;   // odd row: add upper row from line store
      idx_type   idx;
      logic      frame_end;
   } work_type;

   typedef struct packed {
      sum_type blue;
      sum_type red;
   } line_type;

endpackage

/* rtl/ry420_front.sv */
// ----------------------------------------------------------------------------
// ry420_front - CSRs, raster counters and pixel classification
// Takes pixels, tags each with its chroma operation and line store slot.
// ----------------------------------------------------------------------------
module ry420_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  ry420_pkg::pixel_type    req_word,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  ry420_pkg::csr_idx_type  csr_index,
   input  ry420_pkg::csr_data_type csr_data,
   input  logic                    q_full,
   output logic                    q_push,
   output ry420_pkg::work_type     q_word
);

   logic                subsample_ff;
   ry420_pkg::size_type width_ff;
   ry420_pkg::size_type height_ff;
   ry420_pkg::cnt_type  col_ff, col_in;
   ry420_pkg::cnt_type  row_ff, row_in;

   ry420_pkg::size_type width_eff, height_eff;
   ry420_pkg::cnt_type  w_last, h_last;
   logic                col_last, row_last, accept;
   ry420_pkg::op_type   op;

   assign csr_ready = 1'b1;
   assign full      = q_full;
   assign accept    = push && !q_full;
   assign q_push    = accept;

   // zero size acts as 1, oversize saturates
   always_comb begin
      priority if (width_ff == '0) begin
         width_eff = ry420_pkg::size_type'(1);
      end else if (width_ff > ry420_pkg::size_type'(ry420_pkg::MAX_WIDTH)) begin
         width_eff = ry420_pkg::size_type'(ry420_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      priority if (height_ff == '0) begin
         height_eff = ry420_pkg::size_type'(1);
      end else if (height_ff > ry420_pkg::size_type'(ry420_pkg::MAX_HEIGHT)) begin
         height_eff = ry420_pkg::size_type'(ry420_pkg::MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
   end

   assign w_last   = ry420_pkg::cnt_type'(width_eff - ry420_pkg::size_type'(1));
   assign h_last   = ry420_pkg::cnt_type'(height_eff - ry420_pkg::size_type'(1));
   assign col_last = col_ff >= w_last;
   assign row_last = row_ff >= h_last;

   always_comb begin
      priority if (!subsample_ff) begin
         op = ry420_pkg::OP_PIXEL;
      end else if (!col_ff[0] && !col_last) begin
         op = ry420_pkg::OP_HOLD;
      end else if (!row_ff[0] && !row_last) begin
         op = ry420_pkg::OP_STORE;
      end else begin
         op = ry420_pkg::OP_EMIT;
      end
   end

   always_comb begin
      q_word.pixel     = req_word;
      q_word.op        = op;
      q_word.pair_add  = col_ff[0];
      q_word.line_add  = row_ff[0];
      q_word.idx       = col_ff[ry420_pkg::IDX_W:1];
      q_word.frame_end = col_last && row_last;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ry420_pkg::cnt_type'(1);
         end else begin
            col_in = col_ff + ry420_pkg::cnt_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         subsample_ff <= 1'b0;
         width_ff     <= ry420_pkg::RESET_WIDTH;
         height_ff    <= ry420_pkg::RESET_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ry420_pkg::CSR_SUBSAMPLE: subsample_ff <= csr_data[0];
               ry420_pkg::CSR_WIDTH:     width_ff     <= csr_data;
               ry420_pkg::CSR_HEIGHT:    height_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

/* rtl/ry420_queue.sv */
// ----------------------------------------------------------------------------
// ry420_queue - work queue between front end and back end
// Small register FIFO of tagged pixels.
// ----------------------------------------------------------------------------
`include "rgb_to_ycbcr_420_top_defines.svh"

module ry420_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ry420_pkg::work_type push_word,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output ry420_pkg::work_type head
);

   ry420_pkg::work_type    store_ff [ry420_pkg::MID_DEPTH];
   ry420_pkg::mid_ptr_type wr_ptr_ff, rd_ptr_ff;
   ry420_pkg::mid_cnt_type count_ff, count_in;

   assign full  = count_ff == ry420_pkg::mid_cnt_type'(ry420_pkg::MID_DEPTH);
   assign empty = count_ff == '0;
   assign head  = store_ff[rd_ptr_ff];

   assign count_in = count_ff + ry420_pkg::mid_cnt_type'(push)
                     - ry420_pkg::mid_cnt_type'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + ry420_pkg::mid_ptr_type'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + ry420_pkg::mid_ptr_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

   `RY420_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, count_ff != '0, "work queue popped empty")
   `RY420_ASSERT_IMPLIES(a_no_overflow, clock, reset, push && !pop, !full, "work queue pushed full")

endmodule

/* rtl/ry420_back.sv */
// ----------------------------------------------------------------------------
// ry420_back - color math and chroma block averaging
// Four-stage pipeline: products, sums/clamp, pair/line sums, averaging.
// ----------------------------------------------------------------------------
`include "rgb_to_ycbcr_420_top_defines.svh"

module ry420_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  ry420_pkg::work_type    q_head,
   output logic                   q_pop,
   input  logic                   out_pop,
   input  ry420_pkg::out_cnt_type out_count,
   output logic                   out_push,
   output ry420_pkg::result_type  out_word
);

   typedef struct packed {
      ry420_pkg::prod_type yr, yg, yb;
      ry420_pkg::prod_type br, bg, bb;
      ry420_pkg::prod_type rr, rg, rb;
   } prod_set_type;

   function automatic ry420_pkg::q_type clamp_q(input ry420_pkg::sq_type v);
      begin
         if (v < 0) begin
            clamp_q = '0;
         end else if (v > ry420_pkg::sq_type'(ry420_pkg::Q_MAX)) begin
            clamp_q = ry420_pkg::Q_MAX;
         end else begin
            clamp_q = ry420_pkg::q_type'(v);
         end
      end
   endfunction

   function automatic ry420_pkg::pix_type sat8(input ry420_pkg::avg_type v);
      begin
         if (v > ry420_pkg::avg_type'(255)) begin
            sat8 = '1;
         end else begin
            sat8 = ry420_pkg::pix_type'(v);
         end
      end
   endfunction

   // issue / credit
   logic                   issue;
   ry420_pkg::out_cnt_type reserved_ff, reserved_in;

   // stage 1
   logic                   v1_ff;
   ry420_pkg::work_type    w1_ff;
   prod_set_type           prod_in;

   // stage 2
   logic                   v2_ff;
   ry420_pkg::work_type    w2_ff;
   prod_set_type           prod_ff;
   ry420_pkg::q_type       y_q, cb_q, cr_q;

   // stage 3
   logic                   v3_ff;
   ry420_pkg::work_type    w3_ff;
   ry420_pkg::pix_type     y3_ff;
   ry420_pkg::q_type       cbq3_ff, crq3_ff;
   ry420_pkg::line_type    line_sum_ff [ry420_pkg::LINE_DEPTH];
   ry420_pkg::line_type    line_rd_ff;
   logic                   fwd_hit_ff;
   ry420_pkg::line_type    fwd_data_ff;
   ry420_pkg::line_type    pair_ff, pair_in;
   ry420_pkg::line_type    line_val;
   logic                   line_wr;
   ry420_pkg::blk_type     blk_b_in, blk_r_in;
   ry420_pkg::sum_type     rnd_b, rnd_r;
   ry420_pkg::pix_type     px_b_in, px_r_in;
   logic [1:0]             k_in;

   // stage 4
   logic                   v4_ff;
   ry420_pkg::pix_type     y4_ff;
   ry420_pkg::op_type      op4_ff;
   logic [1:0]             k4_ff;
   ry420_pkg::blk_type     blk_b4_ff, blk_r4_ff;
   ry420_pkg::pix_type     px_b4_ff, px_r4_ff;
   logic                   fe4_ff;
   ry420_pkg::blk_type     tb, tr;
   ry420_pkg::pix_type     avg_b, avg_r;

   // one slot of output queue reserved per word in flight
   assign issue = !q_empty && (reserved_ff < ry420_pkg::out_cnt_type'(ry420_pkg::OUT_DEPTH));
   assign q_pop = issue;
   assign reserved_in = reserved_ff + ry420_pkg::out_cnt_type'(issue)
                        - ry420_pkg::out_cnt_type'(out_pop);

   // stage 1: constant products
   always_comb begin
      prod_in.yr = ry420_pkg::prod_type'(w1_ff.pixel.red)   * ry420_pkg::prod_type'(ry420_pkg::C_Y_R);
      prod_in.yg = ry420_pkg::prod_type'(w1_ff.pixel.green) * ry420_pkg::prod_type'(ry420_pkg::C_Y_G);
      prod_in.yb = ry420_pkg::prod_type'(w1_ff.pixel.blue)  * ry420_pkg::prod_type'(ry420_pkg::C_Y_B);
      prod_in.br = ry420_pkg::prod_type'(w1_ff.pixel.red)   * ry420_pkg::prod_type'(ry420_pkg::C_CB_R);
      prod_in.bg = ry420_pkg::prod_type'(w1_ff.pixel.green) * ry420_pkg::prod_type'(ry420_pkg::C_CB_G);
      prod_in.bb = ry420_pkg::prod_type'(w1_ff.pixel.blue)  * ry420_pkg::prod_type'(ry420_pkg::C_HALF);
      prod_in.rr = ry420_pkg::prod_type'(w1_ff.pixel.red)   * ry420_pkg::prod_type'(ry420_pkg::C_HALF);
      prod_in.rg = ry420_pkg::prod_type'(w1_ff.pixel.green) * ry420_pkg::prod_type'(ry420_pkg::C_CR_G);
      prod_in.rb = ry420_pkg::prod_type'(w1_ff.pixel.blue)  * ry420_pkg::prod_type'(ry420_pkg::C_CR_B);
   end

   // stage 2: sums and clamp to [0, 255.0]
   always_comb begin
      y_q  = clamp_q(ry420_pkg::sq_type'(prod_ff.yr) + ry420_pkg::sq_type'(prod_ff.yg)
                     + ry420_pkg::sq_type'(prod_ff.yb));
      cb_q = clamp_q(ry420_pkg::sq_type'(ry420_pkg::Q_OFFSET) + ry420_pkg::sq_type'(prod_ff.bb)
                     - ry420_pkg::sq_type'(prod_ff.br) - ry420_pkg::sq_type'(prod_ff.bg));
      cr_q = clamp_q(ry420_pkg::sq_type'(ry420_pkg::Q_OFFSET) + ry420_pkg::sq_type'(prod_ff.rr)
                     - ry420_pkg::sq_type'(prod_ff.rg) - ry420_pkg::sq_type'(prod_ff.rb));
   end

   // stage 3: pair sum, line store, block sum, per-pixel rounding
   always_comb begin
      if (w3_ff.pair_add) begin
         pair_in.blue = pair_ff.blue + ry420_pkg::sum_type'(cbq3_ff);
         pair_in.red  = pair_ff.red  + ry420_pkg::sum_type'(crq3_ff);
      end else begin
         pair_in.blue = ry420_pkg::sum_type'(cbq3_ff);
         pair_in.red  = ry420_pkg::sum_type'(crq3_ff);
      end
      line_wr  = v3_ff && (w3_ff.op == ry420_pkg::OP_STORE);
      // entry written while this word was reading it is not yet in the read data
      line_val = fwd_hit_ff ? fwd_data_ff : line_rd_ff;
      blk_b_in = ry420_pkg::blk_type'(pair_in.blue);
      blk_r_in = ry420_pkg::blk_type'(pair_in.red);
      if (w3_ff.line_add) begin
         blk_b_in = blk_b_in + ry420_pkg::blk_type'(line_val.blue);
         blk_r_in = blk_r_in + ry420_pkg::blk_type'(line_val.red);
      end
      // block of 1, 2 or 4 pixels: divide by 2^k
      k_in    = 2'(w3_ff.pair_add) + 2'(w3_ff.line_add);
      rnd_b   = ry420_pkg::sum_type'(cbq3_ff) + ry420_pkg::sum_type'(ry420_pkg::ROUND_Q);
      rnd_r   = ry420_pkg::sum_type'(crq3_ff) + ry420_pkg::sum_type'(ry420_pkg::ROUND_Q);
      px_b_in = sat8(ry420_pkg::avg_type'(rnd_b >> ry420_pkg::FRAC_BITS));
      px_r_in = sat8(ry420_pkg::avg_type'(rnd_r >> ry420_pkg::FRAC_BITS));
   end

   // stage 4: round(sum / 2^k), ties up
   always_comb begin
      tb    = blk_b4_ff + (ry420_pkg::blk_type'(ry420_pkg::ROUND_Q) << k4_ff);
      tr    = blk_r4_ff + (ry420_pkg::blk_type'(ry420_pkg::ROUND_Q) << k4_ff);
      avg_b = sat8(ry420_pkg::avg_type'(tb >> (ry420_pkg::FRAC_BITS + int'(k4_ff))));
      avg_r = sat8(ry420_pkg::avg_type'(tr >> (ry420_pkg::FRAC_BITS + int'(k4_ff))));
   end

   always_comb begin
      out_word.luma      = y4_ff;
      out_word.frame_end = fe4_ff;
      unique case (op4_ff)
         ry420_pkg::OP_PIXEL: begin
            out_word.chroma_blue  = px_b4_ff;
            out_word.chroma_red   = px_r4_ff;
            out_word.chroma_valid = 1'b1;
         end
         ry420_pkg::OP_EMIT: begin
            out_word.chroma_blue  = avg_b;
            out_word.chroma_red   = avg_r;
            out_word.chroma_valid = 1'b1;
         end
         default: begin
            out_word.chroma_blue  = '0;
            out_word.chroma_red   = '0;
            out_word.chroma_valid = 1'b0;
         end
      endcase
   end

   assign out_push = v4_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         pair_ff     <= '0;
      end else begin
         reserved_ff <= reserved_in;
         v1_ff       <= issue;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         v4_ff       <= v3_ff;
         fwd_hit_ff  <= line_wr && (w2_ff.idx == w3_ff.idx);
         if (v3_ff && (w3_ff.op != ry420_pkg::OP_PIXEL)) begin
            pair_ff <= pair_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      w1_ff       <= q_head;
      w2_ff       <= w1_ff;
      prod_ff     <= prod_in;
      w3_ff       <= w2_ff;
      y3_ff       <= y_q[ry420_pkg::Q_W-1:ry420_pkg::FRAC_BITS];
      cbq3_ff     <= cb_q;
      crq3_ff     <= cr_q;
      fwd_data_ff <= pair_in;
      y4_ff       <= y3_ff;
      op4_ff      <= w3_ff.op;
      k4_ff       <= k_in;
      blk_b4_ff   <= blk_b_in;
      blk_r4_ff   <= blk_r_in;
      px_b4_ff    <= px_b_in;
      px_r4_ff    <= px_r_in;
      fe4_ff      <= w3_ff.frame_end;
   end

   // upper row pair sums
   always_ff @(posedge clock) begin
      if (line_wr) begin
         line_sum_ff[w3_ff.idx] <= pair_in;
      end
      line_rd_ff <= line_sum_ff[w2_ff.idx];
   end

   `RY420_ASSERT_ALWAYS(a_credit_balance, clock, reset, reserved_ff == ry420_pkg::out_cnt_type'(out_count + ry420_pkg::out_cnt_type'($countones({v1_ff, v2_ff, v3_ff, v4_ff}))), "output credit out of step with words in flight")

endmodule

/* rtl/ry420_out_queue.sv */
// ----------------------------------------------------------------------------
// ry420_out_queue - result queue
// Holds finished words until the consumer pops them.
// ----------------------------------------------------------------------------
`include "rgb_to_ycbcr_420_top_defines.svh"

module ry420_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ry420_pkg::result_type  push_word,
   input  logic                   pop,
   output logic                   empty,
   output ry420_pkg::result_type  head,
   output ry420_pkg::out_cnt_type count
);

   ry420_pkg::result_type  store_ff [ry420_pkg::OUT_DEPTH];
   ry420_pkg::out_ptr_type wr_ptr_ff, rd_ptr_ff;
   ry420_pkg::out_cnt_type count_ff, count_in;
   logic                   pop_ok;

   assign empty  = count_ff == '0;
   assign pop_ok = pop && !empty;
   assign head   = store_ff[rd_ptr_ff];
   assign count  = count_ff;

   assign count_in = count_ff + ry420_pkg::out_cnt_type'(push)
                     - ry420_pkg::out_cnt_type'(pop_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + ry420_pkg::out_ptr_type'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + ry420_pkg::out_ptr_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

   `RY420_ASSERT_IMPLIES(a_no_overflow, clock, reset, push, count_ff != ry420_pkg::out_cnt_type'(ry420_pkg::OUT_DEPTH), "result queue written while full")

endmodule

/* rtl/rgb_to_ycbcr_420_top.sv */
// An accepted push passes the work queue and back-end stages into the result queue.
// Throughput: one word per cycle in and out while full and empty allow; the back pipeline
//   issues one word per cycle from the work queue while it holds an output-queue credit.
// Reset (synchronous): clears counters, pair sums, queues and credits, and
//   restores 4:4:4 mode at 640x480. The line store is not cleared.
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_420_top - RGB to YCbCr (BT.601 full range) with 4:2:0 option
// Front end tags each pixel, a work queue decouples it from the back-end
// pipeline, and a result queue holds finished words for the consumer.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_420_top (
   input  logic                    clock,
   input  logic                    reset,
   // pixel input queue
   input  logic                    push,
   output logic                    full,
   input  ry420_pkg::pixel_type    req_word,
   // result queue
   output logic                    empty,
   input  logic                    pop,
   output ry420_pkg::result_type   rsp_word,
   // CSR write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  ry420_pkg::csr_idx_type  csr_index,
   input  ry420_pkg::csr_data_type csr_data
);

   // front end -> work queue
   logic                   wq_push;
   ry420_pkg::work_type    wq_word;
   logic                   wq_full;
   // work queue -> back end
   logic                   wq_pop;
   logic                   wq_empty;
   ry420_pkg::work_type    wq_head;
   // back end -> result queue
   logic                   rq_push;
   ry420_pkg::result_type  rq_word;
   ry420_pkg::out_cnt_type rq_count;
   logic                   rsp_take;

   assign rsp_take = pop && !empty;

   // CSRs, raster position, chroma op per pixel
   ry420_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (wq_full),
      .q_push    (wq_push),
      .q_word    (wq_word)
   );

   // short decoupling queue; front stalls only when it fills
   ry420_queue u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (wq_push),
      .push_word (wq_word),
      .full      (wq_full),
      .pop       (wq_pop),
      .empty     (wq_empty),
      .head      (wq_head)
   );

   // non-stalling math pipeline; issues against result queue credits
   ry420_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (wq_empty),
      .q_head    (wq_head),
      .q_pop     (wq_pop),
      .out_pop   (rsp_take),
      .out_count (rq_count),
      .out_push  (rq_push),
      .out_word  (rq_word)
   );

   // result queue seen by the consumer
   ry420_out_queue u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_word (rq_word),
      .pop       (pop),
      .empty     (empty),
      .head      (rsp_word),
      .count     (rq_count)
   );

endmodule
